// ===== hdl/tser_pkg.sv =====
package tser_pkg;

   // Field and register widths
   localparam int RESP_W   = 8;
   localparam int COORD_W  = 12;
   localparam int COUNT_W  = 13;
   localparam int MAXR_W   = 8;
   localparam int Q8_W     = 15;
   localparam int SUM_W    = 20;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 15;

   // Default parameter values
   localparam int MAX_FEATURES_DEF = 4096;
   localparam int COORD_BITS_DEF   = 12;

   // Full scale: 100 percent in Q8
   localparam logic [Q8_W-1:0] FULL_Q8 = 15'd25600;

   // Reset values of the configuration registers
   localparam logic [COUNT_W-1:0] FEAT_TOTAL_RST    = 13'd1;
   localparam logic [MAXR_W-1:0]  MAX_RESPONSE_RST  = 8'd4;
   localparam logic [Q8_W-1:0]    THRESHOLD_RST     = 15'd0;

   // Configuration register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      REG_FEAT_TOTAL    = 2'd0,
      REG_MAX_RESPONSE  = 2'd1,
      REG_THRESHOLD     = 2'd2
   } reg_index_type;

   // Controller states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CALC1,
      ST_CALC2,
      ST_DECIDE,
      ST_DIV,
      ST_FIN
   } state_type;

   // Outcome of the bound test for the current item
   typedef enum logic [1:0] {
      VERDICT_CONTINUE,
      VERDICT_REJECT,
      VERDICT_PASS_LAST
   } verdict_type;

   // Commands from controller to datapath
   typedef struct packed {
      logic take;
      logic calc1;
      logic calc2;
      logic commit;
      logic div_start;
      logic div_step;
      logic load_out;
   } cmd_type;

   // Status from datapath to controller
   typedef struct packed {
      logic        dropping;
      verdict_type verdict;
      logic        div_done;
      logic        out_free;
   } status_type;

endpackage

// ===== hdl/tser_channels.sv =====
interface tser_req_if;
   logic                           valid;
   logic                           ready;
   logic [tser_pkg::RESP_W-1:0]    response_value;
   logic [tser_pkg::COORD_W-1:0]   window_x;
   logic [tser_pkg::COORD_W-1:0]   window_y;
   logic                           last_feature;

   modport source (output valid, response_value, window_x, window_y, last_feature,
                   input ready);
   modport sink   (input valid, response_value, window_x, window_y, last_feature,
                   output ready);
endinterface

interface tser_rsp_if;
   logic                           valid;
   logic                           ready;
   logic                           accepted;
   logic [tser_pkg::Q8_W-1:0]      score_pct_q8;
   logic [tser_pkg::COORD_W-1:0]   result_x;
   logic [tser_pkg::COORD_W-1:0]   result_y;

   modport source (output valid, accepted, score_pct_q8, result_x, result_y,
                   input ready);
   modport sink   (input valid, accepted, score_pct_q8, result_x, result_y,
                   output ready);
endinterface

// ===== hdl/tser_ctrl.sv =====
module tser_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  tser_pkg::status_type status,
   output tser_pkg::cmd_type    cmd
);

   tser_pkg::state_type state_ff, state_in;

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= tser_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and commands
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         tser_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.take = 1'b1;
               // items of a dropped window finish here
               if (!status.dropping) begin
                  state_in = tser_pkg::ST_CALC1;
               end
            end
         end
         tser_pkg::ST_CALC1: begin
            cmd.calc1 = 1'b1;
            state_in  = tser_pkg::ST_CALC2;
         end
         tser_pkg::ST_CALC2: begin
            cmd.calc2 = 1'b1;
            state_in  = tser_pkg::ST_DECIDE;
         end
         tser_pkg::ST_DECIDE: begin
            case (status.verdict)
               tser_pkg::VERDICT_CONTINUE: begin
                  cmd.commit = 1'b1;
                  state_in   = tser_pkg::ST_IDLE;
               end
               tser_pkg::VERDICT_REJECT: begin
                  // hold until the output register can take the item
                  if (status.out_free) begin
                     cmd.commit   = 1'b1;
                     cmd.load_out = 1'b1;
                     state_in     = tser_pkg::ST_IDLE;
                  end
               end
               tser_pkg::VERDICT_PASS_LAST: begin
                  cmd.commit    = 1'b1;
                  cmd.div_start = 1'b1;
                  state_in      = tser_pkg::ST_DIV;
               end
               default: begin
                  state_in = tser_pkg::ST_IDLE;
               end
            endcase
         end
         tser_pkg::ST_DIV: begin
            cmd.div_step = 1'b1;
            if (status.div_done) begin
               state_in = tser_pkg::ST_FIN;
            end
         end
         tser_pkg::ST_FIN: begin
            if (status.out_free) begin
               cmd.load_out = 1'b1;
               state_in     = tser_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = tser_pkg::ST_IDLE;
         end
      endcase
   end

`ifndef SYNTHESIS
   a_take_only_idle: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |-> (state_ff == tser_pkg::ST_IDLE))
      else $error("item taken outside idle");

   a_div_to_fin: assert property (@(posedge clock) disable iff (reset)
      (state_ff == tser_pkg::ST_DIV && status.div_done) |=> (state_ff == tser_pkg::ST_FIN))
      else $error("divider end not followed by finish");

   a_load_when_free: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |-> status.out_free)
      else $error("result loaded over a waiting item");
`endif

endmodule

// ===== hdl/tser_datapath.sv =====
module tser_datapath #(
   parameter int MAX_FEATURES = tser_pkg::MAX_FEATURES_DEF,
   parameter int COORD_BITS   = tser_pkg::COORD_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  tser_pkg::cmd_type                   cmd,
   output tser_pkg::status_type                status,
   // configuration writes
   input  logic                                csr_we,
   input  logic [tser_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [tser_pkg::CSR_DATA_W-1:0]     csr_wdata,
   // input item fields
   input  logic [tser_pkg::RESP_W-1:0]         response_value,
   input  logic [tser_pkg::COORD_W-1:0]        window_x,
   input  logic [tser_pkg::COORD_W-1:0]        window_y,
   input  logic                                last_feature,
   // result item
   input  logic                                rsp_ready,
   output logic                                rsp_valid,
   output logic                                accepted,
   output logic [tser_pkg::Q8_W-1:0]           score_pct_q8,
   output logic [tser_pkg::COORD_W-1:0]        result_x,
   output logic [tser_pkg::COORD_W-1:0]        result_y
);

   localparam int IDX_W = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1;
   localparam logic [IDX_W-1:0] IDX_MAX = IDX_W'(MAX_FEATURES - 1);
   localparam logic [12:0] CNT_CAP = (MAX_FEATURES > 8191) ? 13'd8191
                                                             : 13'(MAX_FEATURES);
   localparam int CMASK_W = (COORD_BITS < tser_pkg::COORD_W) ? COORD_BITS
                                                              : tser_pkg::COORD_W;
   localparam logic [11:0] COORD_MASK = 12'((32'd1 << CMASK_W) - 32'd1);
   localparam logic [19:0] SUM_SAT = 20'hFFFFF;

   // configuration
   logic [12:0] feat_total_ff;
   logic [7:0]  max_response_ff;
   logic [14:0] threshold_ff;

   // window state
   logic [19:0]      running_sum_ff;
   logic [IDX_W-1:0] feature_index_ff;
   logic             dropping_ff;

   // latched item
   logic [7:0]  resp_ff;
   logic [11:0] x_ff, y_ff;
   logic        last_ff;

   // stage one and two
   logic [19:0] sum_new_ff;
   logic [20:0] rem_prod_ff;
   logic [20:0] denom_ff;
   logic [36:0] bound_ff;
   logic [35:0] thr_side_ff;
   logic [34:0] num_ff;
   logic [35:0] den_full_ff;

   // divider
   logic [34:0] rem_ff;
   logic [14:0] quot_ff;
   logic [3:0]  step_ff;

   // output register
   logic        rsp_valid_ff;
   logic        accepted_ff;
   logic [14:0] score_ff;
   logic [11:0] rx_ff, ry_ff;

   logic [12:0] count_eff;
   logic [7:0]  maxr_eff;
   logic [20:0] sum_wide;
   logic [19:0] sum_new;
   logic [16:0] idx_p1, cnt17, rem17;
   logic [12:0] remaining;
   logic [35:0] trial;
   logic        acc_flag, sat_flag;
   tser_pkg::verdict_type verdict;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         feat_total_ff    <= tser_pkg::FEAT_TOTAL_RST;
         max_response_ff  <= tser_pkg::MAX_RESPONSE_RST;
         threshold_ff     <= tser_pkg::THRESHOLD_RST;
      end else if (csr_we) begin
         case (csr_index)
            tser_pkg::REG_FEAT_TOTAL:    feat_total_ff    <= csr_wdata[12:0];
            tser_pkg::REG_MAX_RESPONSE:  max_response_ff  <= csr_wdata[7:0];
            tser_pkg::REG_THRESHOLD:     threshold_ff     <= csr_wdata[14:0];
            default: ;
         endcase
      end
   end

   // Effective count and maximum: zero acts as one, count capped
   always_comb begin
      if (feat_total_ff == 13'd0) begin
         count_eff = 13'd1;
      end else if (feat_total_ff > CNT_CAP) begin
         count_eff = CNT_CAP;
      end else begin
         count_eff = feat_total_ff;
      end
      maxr_eff = (max_response_ff == 8'd0) ? 8'd1 : max_response_ff;
   end

   // Saturating sum and features still to come
   always_comb begin
      sum_wide  = 21'(running_sum_ff) + 21'(resp_ff);
      sum_new   = sum_wide[20] ? SUM_SAT : sum_wide[19:0];
      idx_p1    = 17'(feature_index_ff) + 17'd1;
      cnt17     = 17'(count_eff);
      rem17     = (cnt17 > idx_p1) ? (cnt17 - idx_p1) : 17'd0;
      remaining = rem17[12:0];
   end

   // Bound test and verdict
   always_comb begin
      if (37'(thr_side_ff) > bound_ff) begin
         verdict = tser_pkg::VERDICT_REJECT;
      end else if (last_ff) begin
         verdict = tser_pkg::VERDICT_PASS_LAST;
      end else begin
         verdict = tser_pkg::VERDICT_CONTINUE;
      end
      acc_flag = 36'(num_ff) >= thr_side_ff;
      sat_flag = 36'(num_ff) >= den_full_ff;
      trial    = 36'(denom_ff) << step_ff;
   end

   // Latch item, evaluate in two steps
   always_ff @(posedge clock) begin
      if (cmd.take) begin
         resp_ff <= response_value;
         x_ff    <= window_x & COORD_MASK;
         y_ff    <= window_y & COORD_MASK;
         last_ff <= last_feature;
      end
      if (cmd.calc1) begin
         sum_new_ff  <= sum_new;
         rem_prod_ff <= 21'(remaining) * 21'(maxr_eff);
         denom_ff    <= 21'(count_eff) * 21'(maxr_eff);
      end
      if (cmd.calc2) begin
         bound_ff    <= 37'(22'(sum_new_ff) + 22'(rem_prod_ff)) * 37'(tser_pkg::FULL_Q8);
         thr_side_ff <= 36'(threshold_ff) * 36'(denom_ff);
         num_ff      <= 35'(sum_new_ff) * 35'(tser_pkg::FULL_Q8);
         den_full_ff <= 36'(denom_ff) * 36'(tser_pkg::FULL_Q8);
      end
   end

   // Window state: advance, reject or close the window
   always_ff @(posedge clock) begin
      if (reset) begin
         running_sum_ff   <= '0;
         feature_index_ff <= '0;
         dropping_ff      <= 1'b0;
      end else if (cmd.take && dropping_ff) begin
         if (last_feature) begin
            running_sum_ff   <= '0;
            feature_index_ff <= '0;
            dropping_ff      <= 1'b0;
         end
      end else if (cmd.commit) begin
         case (verdict)
            tser_pkg::VERDICT_CONTINUE: begin
               running_sum_ff <= sum_new_ff;
               if (feature_index_ff < IDX_MAX) begin
                  feature_index_ff <= feature_index_ff + 1'b1;
               end
            end
            tser_pkg::VERDICT_REJECT: begin
               running_sum_ff   <= '0;
               feature_index_ff <= '0;
               dropping_ff      <= !last_ff;
            end
            default: begin
               running_sum_ff   <= '0;
               feature_index_ff <= '0;
               dropping_ff      <= 1'b0;
            end
         endcase
      end
   end

   // Restoring divider, one quotient bit a cycle
   always_ff @(posedge clock) begin
      if (cmd.div_start) begin
         rem_ff  <= num_ff;
         quot_ff <= '0;
         step_ff <= 4'd14;
      end else if (cmd.div_step) begin
         if (36'(rem_ff) >= trial) begin
            rem_ff          <= 35'(36'(rem_ff) - trial);
            quot_ff[step_ff] <= 1'b1;
         end
         step_ff <= step_ff - 4'd1;
      end
   end

   // Output register: hold a result until taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_out) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         rx_ff <= x_ff;
         ry_ff <= y_ff;
         if (verdict == tser_pkg::VERDICT_REJECT) begin
            accepted_ff <= 1'b0;
            score_ff    <= '0;
         end else begin
            accepted_ff <= acc_flag;
            score_ff    <= sat_flag ? tser_pkg::FULL_Q8 : quot_ff;
         end
      end
   end

   assign status.dropping = dropping_ff;
   assign status.verdict  = verdict;
   assign status.div_done = (step_ff == 4'd0);
   assign status.out_free = !rsp_valid_ff || rsp_ready;

   assign rsp_valid    = rsp_valid_ff;
   assign accepted     = accepted_ff;
   assign score_pct_q8 = score_ff;
   assign result_x     = rx_ff;
   assign result_y     = ry_ff;

`ifndef SYNTHESIS
   a_reject_drops: assert property (@(posedge clock) disable iff (reset)
      (cmd.commit && verdict == tser_pkg::VERDICT_REJECT && !last_ff) |=> dropping_ff)
      else $error("reject mid-window did not start dropping");

   a_window_closed: assert property (@(posedge clock) disable iff (reset)
      (cmd.commit && verdict != tser_pkg::VERDICT_CONTINUE)
         |=> (running_sum_ff == '0 && feature_index_ff == '0))
      else $error("window state not cleared at window end");

   a_score_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (score_ff <= tser_pkg::FULL_Q8))
      else $error("score above full scale");
`endif

endmodule

// ===== hdl/template_similarity_early_reject.sv =====
// Channel   Dir  Fields                                              Handshake
// req_ch    in   response_value, window_x, window_y, last_feature    valid/ready
// rsp_ch    out  accepted, score_pct_q8, result_x, result_y          valid/ready
// csr_*     in   csr_index, csr_wdata                                csr_we
//
// An item of a dropped window is only taken; any other item passes through
// take, two arithmetic steps and the bound decision, and the last item of a
// surviving window then runs the 15-step restoring divider.
// Reset is synchronous; it clears the window state and output valid, and
// loads a feature total of 1, max_response 4, threshold 0.
// A result waits in the output register while the next item is taken; only
// a further result stalls, holding its final step until the register frees.
module template_similarity_early_reject #(
   parameter int MAX_FEATURES = tser_pkg::MAX_FEATURES_DEF,
   parameter int COORD_BITS   = tser_pkg::COORD_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   tser_req_if.sink                        req_ch,
   tser_rsp_if.source                      rsp_ch,
   input  logic                            csr_we,
   input  logic [tser_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [tser_pkg::CSR_DATA_W-1:0] csr_wdata
);

   tser_pkg::cmd_type    cmd;
   tser_pkg::status_type status;

   tser_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .status    (status),
      .cmd       (cmd)
   );

   tser_datapath #(
      .MAX_FEATURES (MAX_FEATURES),
      .COORD_BITS   (COORD_BITS)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .response_value (req_ch.response_value),
      .window_x       (req_ch.window_x),
      .window_y       (req_ch.window_y),
      .last_feature   (req_ch.last_feature),
      .rsp_ready      (rsp_ch.ready),
      .rsp_valid      (rsp_ch.valid),
      .accepted       (rsp_ch.accepted),
      .score_pct_q8   (rsp_ch.score_pct_q8),
      .result_x       (rsp_ch.result_x),
      .result_y       (rsp_ch.result_y)
   );

endmodule

// ===== bench/testbench.sv =====
module testbench;

   localparam int     SETTLE_CYCLES = 40;      // beyond the slowest item (divider pass)
   localparam int     HOLD_CYCLES   = 300;
   localparam int     RANDOM_ITEMS  = 850;
   localparam int     DRAIN_LIMIT   = 100000;
   localparam int     INDEX_W       = 12;
   localparam longint WATCHDOG_TIME = 64'd40000000;
   localparam longint unsigned SUM_LIMIT  = (64'd1 << tser_pkg::SUM_W) - 64'd1;
   localparam longint unsigned FULL_SCALE = 64'(tser_pkg::FULL_Q8);

   typedef struct packed {
      logic [tser_pkg::RESP_W-1:0]  response_value;
      logic [tser_pkg::COORD_W-1:0] window_x;
      logic [tser_pkg::COORD_W-1:0] window_y;
      logic                         last_feature;
   } feature_item_type;

   typedef struct packed {
      logic                         accepted;
      logic [tser_pkg::Q8_W-1:0]    score_pct_q8;
      logic [tser_pkg::COORD_W-1:0] result_x;
      logic [tser_pkg::COORD_W-1:0] result_y;
   } window_result_type;

   logic                            clock;
   logic                            reset;
   logic                            csr_we;
   logic [tser_pkg::CSR_IDX_W-1:0]  csr_index;
   logic [tser_pkg::CSR_DATA_W-1:0] csr_wdata;

   tser_req_if req_if();
   tser_rsp_if rsp_if();

   template_similarity_early_reject DUT (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_if),
      .rsp_ch    (rsp_if),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // Shadow copy of the scoring registers and the window accumulator
   logic [tser_pkg::COUNT_W-1:0] cfg_feat_total     = tser_pkg::FEAT_TOTAL_RST;
   logic [tser_pkg::MAXR_W-1:0]  cfg_max_response   = tser_pkg::MAX_RESPONSE_RST;
   logic [tser_pkg::Q8_W-1:0]    cfg_threshold      = tser_pkg::THRESHOLD_RST;
   logic [tser_pkg::SUM_W-1:0]   acc_sum   = '0;
   logic [INDEX_W-1:0]           acc_index = '0;
   logic                         skipping  = 1'b0;

   window_result_type pending_verdicts[$];
   int unsigned       sent_items     = 0;
   int unsigned       mismatch_count = 0;
   int unsigned       hold_requests  = 0;
   int unsigned       holds_served   = 0;
   bit                steady_send    = 1'b0;

   // Clock
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Watchdog
   initial begin
      #(WATCHDOG_TIME);
      $display("Verification failed");
      $finish;
   end

   function automatic longint unsigned effective_count();
      if (cfg_feat_total == 0) return 1;
      if (cfg_feat_total > tser_pkg::MAX_FEATURES_DEF) return tser_pkg::MAX_FEATURES_DEF;
      return cfg_feat_total;
   endfunction

   function automatic longint unsigned effective_max();
      return (cfg_max_response == 0) ? 1 : cfg_max_response;
   endfunction

   // Mostly back-to-back, sometimes a short gap, now and then a long one
   function automatic int idle_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Score one feature against the upper bound; returns 1 when it yields a verdict
   function automatic bit score_feature(input feature_item_type item,
                                        output window_result_type verdict);
      longint unsigned count, maxr, denom, thr_side, sum, remaining, score;
      count    = effective_count();
      maxr     = effective_max();
      denom    = count * maxr;
      thr_side = 64'(cfg_threshold) * denom;
      verdict  = '0;
      verdict.result_x = item.window_x;
      verdict.result_y = item.window_y;
      // drop the rest of a rejected window
      if (skipping) begin
         if (item.last_feature) skipping = 1'b0;
         return 1'b0;
      end
      sum = 64'(acc_sum) + item.response_value;
      if (sum > SUM_LIMIT) sum = SUM_LIMIT;
      remaining = (count > 64'(acc_index) + 1) ? count - acc_index - 1 : 0;
      // best reachable score below threshold: reject now
      if (FULL_SCALE * (sum + remaining * maxr) < thr_side) begin
         acc_sum   = '0;
         acc_index = '0;
         skipping  = !item.last_feature;
         return 1'b1;
      end
      if (item.last_feature) begin
         score = (FULL_SCALE * sum) / denom;
         if (score > FULL_SCALE) score = FULL_SCALE;
         verdict.accepted     = (FULL_SCALE * sum >= thr_side);
         verdict.score_pct_q8 = score[tser_pkg::Q8_W-1:0];
         acc_sum   = '0;
         acc_index = '0;
         return 1'b1;
      end
      acc_sum = sum[tser_pkg::SUM_W-1:0];
      if (acc_index < tser_pkg::MAX_FEATURES_DEF - 1) acc_index++;
      return 1'b0;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      mismatch_count++;
      $display("%0t mismatch: %s got %0d expected %0d", $time, what, got, want);
   endtask

   // Offer one item, hold it until taken, then predict its verdict
   task automatic send_feature(input logic [tser_pkg::RESP_W-1:0] value,
                               input logic [tser_pkg::COORD_W-1:0] x,
                               input logic [tser_pkg::COORD_W-1:0] y, input logic last);
      int                gap;
      feature_item_type  item;
      window_result_type verdict;
      gap = steady_send ? 0 : idle_gap();
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid          <= 1'b1;
      req_if.response_value <= value;
      req_if.window_x       <= x;
      req_if.window_y       <= y;
      req_if.last_feature   <= last;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      sent_items++;
      item = '{value, x, y, last};
      if (score_feature(item, verdict))
         pending_verdicts.insert(pending_verdicts.size(), verdict);
   endtask

   task automatic write_register(input tser_pkg::reg_index_type index,
                                 input int unsigned value);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= tser_pkg::CSR_DATA_W'(value);
      @(posedge clock);
      csr_we <= 1'b0;
      case (index)
         tser_pkg::REG_FEAT_TOTAL:   cfg_feat_total   = tser_pkg::COUNT_W'(value);
         tser_pkg::REG_MAX_RESPONSE: cfg_max_response = tser_pkg::MAXR_W'(value);
         tser_pkg::REG_THRESHOLD:    cfg_threshold    = tser_pkg::Q8_W'(value);
         default: ;
      endcase
   endtask

   // Stop offering, wait for every verdict, then let the last item finish
   task automatic settle_block();
      req_if.valid <= 1'b0;
      while (pending_verdicts.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic program_scoring(input int unsigned count, input int unsigned maxr,
                                  input int unsigned thr);
      settle_block();
      write_register(tser_pkg::REG_FEAT_TOTAL, count);
      write_register(tser_pkg::REG_MAX_RESPONSE, maxr);
      write_register(tser_pkg::REG_THRESHOLD, thr);
   endtask

   // Register defaults: one feature per window, max 4, zero threshold
   task automatic test_reset_values();
      send_feature(8'd0, 12'd0, 12'd0, 1'b1);
      send_feature(8'd255, 12'd4095, 12'd4095, 1'b1);
      send_feature(8'd4, 12'd1, 12'd2, 1'b1);
      send_feature(8'd3, 12'd3, 12'd4, 1'b0);
      send_feature(8'd2, 12'd5, 12'd6, 1'b1);
   endtask

   task automatic test_special_cases();
      // early last feature: bound passes but the score misses the threshold
      program_scoring(4, 10, 12801);
      send_feature(8'd10, 12'd10, 12'd20, 1'b0);
      send_feature(8'd10, 12'd10, 12'd20, 1'b1);
      // reject mid-window, drop the rest up to the last feature
      send_feature(8'd0, 12'd30, 12'd40, 1'b0);
      send_feature(8'd0, 12'd30, 12'd40, 1'b0);
      send_feature(8'd7, 12'd30, 12'd40, 1'b0);
      send_feature(8'd9, 12'd30, 12'd40, 1'b1);
      // full window that reaches the threshold
      send_feature(8'd10, 12'd50, 12'd60, 1'b0);
      send_feature(8'd10, 12'd50, 12'd60, 1'b0);
      send_feature(8'd10, 12'd50, 12'd60, 1'b0);
      send_feature(8'd0, 12'd51, 12'd61, 1'b1);
      // reject on the last feature itself
      send_feature(8'd0, 12'd70, 12'd80, 1'b0);
      send_feature(8'd0, 12'd70, 12'd80, 1'b1);
      // zero count and zero max act as one; threshold above full scale
      program_scoring(0, 0, 32767);
      send_feature(8'd1, 12'd90, 12'd91, 1'b1);
      send_feature(8'd255, 12'd92, 12'd93, 1'b1);
      // count beyond the feature limit is clamped
      program_scoring(8191, 255, 25600);
      send_feature(8'd254, 12'd100, 12'd101, 1'b0);
      send_feature(8'd255, 12'd100, 12'd101, 1'b1);
   endtask

   // Window far longer than the feature total: remaining stays at zero, score saturates
   task automatic test_overlong_window();
      logic [tser_pkg::COORD_W-1:0] x, y;
      program_scoring(8, 255, 25600);
      x = tser_pkg::COORD_W'($urandom);
      y = tser_pkg::COORD_W'($urandom);
      repeat (40) send_feature(8'd255, x, y, 1'b0);
      send_feature(8'd255, x, y, 1'b1);
      // the next window must start from a clean accumulator
      send_feature(8'd255, x, y, 1'b1);
   endtask

   // Receiver holds off while single-feature windows keep coming
   task automatic test_output_backpressure();
      program_scoring(1, 255, 12800);
      hold_requests++;
      steady_send = 1'b1;
      repeat (40)
         send_feature(tser_pkg::RESP_W'($urandom), tser_pkg::COORD_W'($urandom),
                      tser_pkg::COORD_W'($urandom), 1'b1);
      steady_send = 1'b0;
   endtask

   // Random settings, mostly well-formed windows, some cut short or overrun
   task automatic test_random_windows();
      int unsigned                  start, r, count, maxr, thr, windows, len, style;
      int unsigned                  eff, maxr_eff;
      logic [tser_pkg::COORD_W-1:0] x, y;
      logic [tser_pkg::RESP_W-1:0]  value;
      start = sent_items;
      while (sent_items - start < RANDOM_ITEMS) begin
         r = $urandom_range(0, 99);
         if (r < 60)      count = $urandom_range(1, 8);
         else if (r < 80) count = $urandom_range(9, 40);
         else if (r < 85) count = 4096;
         else if (r < 90) count = $urandom_range(4097, 8191);
         else if (r < 95) count = 0;
         else             count = $urandom_range(41, 200);
         r = $urandom_range(0, 99);
         if (r < 15)      maxr = 255;
         else if (r < 25) maxr = 1;
         else if (r < 30) maxr = 0;
         else             maxr = $urandom_range(2, 254);
         r = $urandom_range(0, 99);
         if (r < 10)      thr = 0;
         else if (r < 20) thr = 25600;
         else if (r < 25) thr = $urandom_range(25601, 32767);
         else if (r < 70) thr = $urandom_range(15000, 25600);
         else             thr = $urandom_range(0, 25600);
         program_scoring(count, maxr, thr);
         eff      = 32'(effective_count());
         maxr_eff = 32'(effective_max());
         windows  = $urandom_range(10, 40);
         for (int w = 0; w < windows && sent_items - start < RANDOM_ITEMS; w++) begin
            r = $urandom_range(0, 99);
            if (eff > 200)              len = $urandom_range(1, 12);
            else if (r < 80)            len = eff;
            else if (r < 90 && eff > 1) len = $urandom_range(1, eff - 1);
            else                        len = eff + $urandom_range(1, 4);
            style = $urandom_range(0, 9);
            x = tser_pkg::COORD_W'($urandom);
            y = tser_pkg::COORD_W'($urandom);
            steady_send = ($urandom_range(0, 4) == 0);
            for (int i = 0; i < len; i++) begin
               if (style < 6)
                  value = tser_pkg::RESP_W'(maxr_eff - $urandom_range(0, maxr_eff / 4));
               else if (style < 9)
                  value = tser_pkg::RESP_W'($urandom_range(0, maxr_eff));
               else
                  value = tser_pkg::RESP_W'($urandom_range(0, 255));
               if ($urandom_range(0, 6) == 0) begin
                  x = tser_pkg::COORD_W'($urandom);
                  y = tser_pkg::COORD_W'($urandom);
               end
               send_feature(value, x, y, i == len - 1);
            end
         end
         steady_send = 1'b0;
      end
   endtask

   // Result receiver: calm and stalling stretches, plus requested long hold-offs
   initial begin : result_sink
      int stall, mode_left, hold_left;
      bit calm;
      stall     = 0;
      mode_left = 0;
      hold_left = 0;
      calm      = 1'b0;
      rsp_if.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (mode_left == 0) begin
            calm      = ($urandom_range(0, 3) == 0);
            mode_left = $urandom_range(50, 300);
         end
         mode_left--;
         if (hold_left == 0 && holds_served != hold_requests) begin
            hold_left = HOLD_CYCLES;
            holds_served++;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_if.ready <= 1'b0;
         end else if (stall > 0) begin
            stall--;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= 1'b1;
            if (!calm && $urandom_range(0, 2) == 0) stall = idle_gap();
         end
      end
   end

   // Compare each verdict with the oldest prediction
   always @(posedge clock) begin : result_check
      window_result_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (pending_verdicts.size() == 0) begin
            report_mismatch("unexpected result, result_x", rsp_if.result_x, 0);
         end else begin
            want = pending_verdicts.pop_front();
            if (rsp_if.accepted !== want.accepted)
               report_mismatch("accepted", rsp_if.accepted, want.accepted);
            if (rsp_if.score_pct_q8 !== want.score_pct_q8)
               report_mismatch("score_pct_q8", rsp_if.score_pct_q8, want.score_pct_q8);
            if (rsp_if.result_x !== want.result_x)
               report_mismatch("result_x", rsp_if.result_x, want.result_x);
            if (rsp_if.result_y !== want.result_y)
               report_mismatch("result_y", rsp_if.result_y, want.result_y);
         end
      end
   end

   initial begin : sequencer
      int drain;
      reset                 = 1'b1;
      csr_we                = 1'b0;
      csr_index             = tser_pkg::REG_FEAT_TOTAL;
      csr_wdata             = '0;
      req_if.valid          = 1'b0;
      req_if.response_value = '0;
      req_if.window_x       = '0;
      req_if.window_y       = '0;
      req_if.last_feature   = 1'b0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      test_reset_values();
      test_special_cases();
      test_overlong_window();
      test_output_backpressure();
      test_random_windows();

      // drain outstanding verdicts, then give the block time to misbehave
      req_if.valid <= 1'b0;
      drain = 0;
      while (pending_verdicts.size() != 0 && drain < DRAIN_LIMIT) begin
         @(posedge clock);
         drain++;
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (pending_verdicts.size() != 0)
         report_mismatch("verdicts never delivered", pending_verdicts.size(), 0);
      if (mismatch_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
